// ===== src/ltb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltb_pkg
// Shared constants, types and helpers for the level threshold binning block.
// ----------------------------------------------------------------------------
package ltb_pkg;

    localparam int TABLE_DEPTH   = 32;
    localparam int IDX_W         = $clog2(TABLE_DEPTH);
    localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);
    localparam int RESET_LEVELS  = (8 > TABLE_DEPTH) ? TABLE_DEPTH : 8;
    localparam int RESET_MAX_Q16 = 6553600;
    localparam int RESET_DELTA   = RESET_MAX_Q16 / (RESET_LEVELS - 1);
    localparam int FRAC_W        = 16;
    localparam int QRY_DIV_STEPS = FRAC_W;
    localparam int FILL_DIV_STEPS = 33;
    localparam int STEP_W        = 6;

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_COMMIT = 2'd1;
    localparam logic [1:0] OP_FILL   = 2'd2;
    localparam logic [1:0] OP_QUERY  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN,
        ST_EVAL,
        ST_DIV,
        ST_FILL,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic dispatch;
        logic scan_step;
        logic scan_eval;
        logic div_step;
        logic div_finish;
        logic fill_step;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       count_ok;
        logic       single;
        logic       scan_last;
        logic       need_div;
        logic       div_done;
        logic       fill_last;
    } sts_t;

    function automatic logic [31:0] reset_level(input int i);
        reset_level = (i < RESET_LEVELS) ? 32'(RESET_DELTA * i) : 32'd0;
    endfunction

endpackage

// ===== src/ltb_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltb_ctrl
// Sequencer: accepts one item, steps the datapath, presents the result.
// ----------------------------------------------------------------------------
module ltb_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    input  ltb_pkg::sts_t sts,
    output ltb_pkg::cmd_t cmd
);

    ltb_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ltb_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ltb_pkg::ST_IDLE: begin
                if (s_valid) state_next = ltb_pkg::ST_DISPATCH;
            end
            ltb_pkg::ST_DISPATCH: begin
                if (sts.op == ltb_pkg::OP_QUERY) begin
                    state_next = ltb_pkg::ST_SCAN;
                end else if (sts.op == ltb_pkg::OP_FILL && sts.count_ok && !sts.single) begin
                    state_next = ltb_pkg::ST_DIV;
                end else begin
                    state_next = ltb_pkg::ST_OUT;
                end
            end
            ltb_pkg::ST_SCAN: begin
                if (sts.scan_last) state_next = ltb_pkg::ST_EVAL;
            end
            ltb_pkg::ST_EVAL: begin
                state_next = sts.need_div ? ltb_pkg::ST_DIV : ltb_pkg::ST_OUT;
            end
            ltb_pkg::ST_DIV: begin
                if (sts.div_done) begin
                    state_next = (sts.op == ltb_pkg::OP_FILL) ? ltb_pkg::ST_FILL
                                                               : ltb_pkg::ST_OUT;
                end
            end
            ltb_pkg::ST_FILL: begin
                if (sts.fill_last) state_next = ltb_pkg::ST_OUT;
            end
            ltb_pkg::ST_OUT: begin
                if (m_ready) state_next = ltb_pkg::ST_IDLE;
            end
            default: state_next = ltb_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            ltb_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ltb_pkg::ST_DISPATCH: cmd.dispatch  = 1'b1;
            ltb_pkg::ST_SCAN:     cmd.scan_step = 1'b1;
            ltb_pkg::ST_EVAL:     cmd.scan_eval = 1'b1;
            ltb_pkg::ST_DIV: begin
                cmd.div_finish = sts.div_done;
                cmd.div_step   = !sts.div_done;
            end
            ltb_pkg::ST_FILL:     cmd.fill_step = 1'b1;
            ltb_pkg::ST_OUT:      m_valid = 1'b1;
            default: ;
        endcase
    end

endmodule

// ===== src/ltb_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltb_datapath
// Level table, linear scan, shared restoring divider, fill accumulator.
// ----------------------------------------------------------------------------
module ltb_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  ltb_pkg::cmd_t       cmd,
    output ltb_pkg::sts_t       sts,
    input  logic [1:0]          s_op,
    input  logic [4:0]          s_entry_index,
    input  logic signed [31:0]  s_entry_value,
    input  logic [7:0]          s_level_count,
    input  logic signed [31:0]  s_range_min,
    input  logic signed [31:0]  s_range_max,
    input  logic signed [31:0]  s_query_value,
    output logic                m_status,
    output logic [5:0]          m_bin_index,
    output logic [21:0]         m_bin_position
);

    localparam int IW = ltb_pkg::IDX_W;
    localparam int CW = ltb_pkg::CNT_W;

    // captured item
    logic [1:0]         op_reg;
    logic [4:0]         eidx_reg;
    logic signed [31:0] eval_reg;
    logic [7:0]         count_reg;
    logic signed [31:0] rmin_reg;
    logic signed [31:0] rmax_reg;
    logic signed [31:0] qval_reg;

    logic signed [31:0] level_reg [ltb_pkg::TABLE_DEPTH];
    logic [CW-1:0]      active_reg;

    logic [IW-1:0]      idx_reg;
    logic               found_reg;
    logic [IW-1:0]      hit_idx_reg;
    logic signed [31:0] prev_reg;
    logic signed [31:0] lo_reg;
    logic signed [31:0] hi_reg;
    logic               gt_last_reg;

    logic [32:0]        rem_reg;
    logic [32:0]        quo_reg;
    logic [32:0]        den_reg;
    logic [ltb_pkg::STEP_W-1:0] dcnt_reg;
    logic               neg_reg;
    logic signed [32:0] delta_reg;
    logic signed [31:0] acc_reg;

    logic               status_reg;
    logic [5:0]         bidx_reg;
    logic [21:0]        bpos_reg;

    logic               count_ok;
    logic [CW-1:0]      count_n;
    logic [IW-1:0]      last_idx;
    logic [IW-1:0]      fill_last_idx;
    logic signed [31:0] rd;
    logic               hit;
    logic signed [32:0] mid_sum;
    logic [32:0]        mid_adj;
    logic signed [32:0] span;
    logic [32:0]        span_mag;
    logic [33:0]        div_shift;
    logic               div_ge;
    logic [33:0]        div_sub;
    logic signed [32:0] qnum;
    logic signed [32:0] qden;

    assign count_ok = (count_reg != 8'd0) && (count_reg <= 8'(ltb_pkg::TABLE_DEPTH));
    assign count_n  = CW'(count_reg);
    assign last_idx = IW'(active_reg - CW'(1));
    assign fill_last_idx = IW'(count_n - CW'(1));
    assign rd       = level_reg[idx_reg];
    assign hit      = qval_reg < rd;

    assign mid_sum  = {rmin_reg[31], rmin_reg} + {rmax_reg[31], rmax_reg};
    assign mid_adj  = mid_sum + {32'd0, mid_sum[32]};   // round toward zero
    assign span     = {rmax_reg[31], rmax_reg} - {rmin_reg[31], rmin_reg};
    assign span_mag = span[32] ? 33'(-span) : span;

    assign div_shift = {rem_reg, quo_reg[32]};
    assign div_ge    = div_shift >= {1'b0, den_reg};
    assign div_sub   = div_shift - {1'b0, den_reg};

    assign qnum = {qval_reg[31], qval_reg} - {lo_reg[31], lo_reg};
    assign qden = {hi_reg[31], hi_reg} - {lo_reg[31], lo_reg};

    always_comb begin
        sts.op        = op_reg;
        sts.count_ok  = count_ok;
        sts.single    = (count_reg == 8'd1);
        sts.scan_last = (idx_reg == last_idx);
        sts.need_div  = found_reg && (hit_idx_reg != '0) && !gt_last_reg;
        sts.div_done  = (dcnt_reg == '0);
        sts.fill_last = (idx_reg == fill_last_idx);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= s_op;
            eidx_reg  <= s_entry_index;
            eval_reg  <= s_entry_value;
            count_reg <= s_level_count;
            rmin_reg  <= s_range_min;
            rmax_reg  <= s_range_max;
            qval_reg  <= s_query_value;
        end

        if (cmd.dispatch) begin
            status_reg <= (op_reg == ltb_pkg::OP_COMMIT || op_reg == ltb_pkg::OP_FILL) &&
                          !count_ok;
            bidx_reg   <= '0;
            bpos_reg   <= '0;
            idx_reg    <= '0;
            found_reg  <= 1'b0;
            if (op_reg == ltb_pkg::OP_FILL) begin
                rem_reg  <= '0;
                quo_reg  <= span_mag;
                den_reg  <= 33'(count_reg) - 33'd1;
                neg_reg  <= span[32];
                dcnt_reg <= ltb_pkg::STEP_W'(ltb_pkg::FILL_DIV_STEPS);
            end
        end

        if (cmd.scan_step) begin
            if (!found_reg && hit) begin
                found_reg   <= 1'b1;
                hit_idx_reg <= idx_reg;
                lo_reg      <= prev_reg;
                hi_reg      <= rd;
            end
            prev_reg    <= rd;
            gt_last_reg <= qval_reg > rd;   // only the last step's value is used
            idx_reg     <= idx_reg + IW'(1);
        end

        if (cmd.scan_eval) begin
            bidx_reg <= found_reg ? 6'(hit_idx_reg) : 6'(active_reg);
            if (found_reg && hit_idx_reg == '0) begin
                bpos_reg <= '0;
            end else if (gt_last_reg) begin
                bpos_reg <= {active_reg, 16'd0};
            end else if (!found_reg) begin
                bpos_reg <= {1'b0, last_idx, 16'd0};
            end
            rem_reg  <= qnum;
            quo_reg  <= '0;
            den_reg  <= qden;
            dcnt_reg <= ltb_pkg::STEP_W'(ltb_pkg::QRY_DIV_STEPS);
        end

        if (cmd.div_step) begin
            rem_reg  <= div_ge ? div_sub[32:0] : div_shift[32:0];
            quo_reg  <= {quo_reg[31:0], div_ge};
            dcnt_reg <= dcnt_reg - ltb_pkg::STEP_W'(1);
        end

        if (cmd.div_finish) begin
            if (op_reg == ltb_pkg::OP_FILL) begin
                delta_reg <= neg_reg ? 33'(-quo_reg) : quo_reg;
                acc_reg   <= rmin_reg;
                idx_reg   <= '0;
            end else begin
                bpos_reg <= {1'b0, hit_idx_reg, quo_reg[15:0]};
            end
        end

        if (cmd.fill_step) begin
            acc_reg <= acc_reg + delta_reg[31:0];
            idx_reg <= idx_reg + IW'(1);
        end
    end

    // level table and active count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ltb_pkg::TABLE_DEPTH; i++) begin
                level_reg[i] <= ltb_pkg::reset_level(i);
            end
            active_reg <= CW'(ltb_pkg::RESET_LEVELS);
        end else begin
            if (cmd.dispatch) begin
                if (op_reg == ltb_pkg::OP_WRITE &&
                    32'(eidx_reg) < 32'(ltb_pkg::TABLE_DEPTH)) begin
                    level_reg[IW'(eidx_reg)] <= eval_reg;
                end
                if ((op_reg == ltb_pkg::OP_COMMIT || op_reg == ltb_pkg::OP_FILL) && count_ok) begin
                    active_reg <= count_n;
                end
                if (op_reg == ltb_pkg::OP_FILL && count_ok && count_reg == 8'd1) begin
                    level_reg[0] <= mid_adj[32:1];
                end
            end
            if (cmd.fill_step) begin
                level_reg[idx_reg] <= acc_reg;
            end
        end
    end

    assign m_status       = status_reg;
    assign m_bin_index    = bidx_reg;
    assign m_bin_position = bpos_reg;

endmodule

// ===== src/level_threshold_binning.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// level_threshold_binning
// Q16.16 threshold quantizer: table writes, count commit, uniform fill, query.
// ----------------------------------------------------------------------------
// Write and commit dispatch straight to the result; a query scans the N active
//   levels, then runs the 16-step divider when it interpolates; uniform fill runs
//   the divider, then one table write per cycle. One item in flight; next item is
//   taken the cycle after the result transfer. Throughput bound by scan and divider.
// Reset: synchronous active-low aresetn loads eight uniform levels from 0 to just
//   under 100, zeros the rest, sets the active count to 8 at a clock edge.
module level_threshold_binning (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_op,
    input  logic [4:0]         s_entry_index,
    input  logic signed [31:0] s_entry_value,
    input  logic [7:0]         s_level_count,
    input  logic signed [31:0] s_range_min,
    input  logic signed [31:0] s_range_max,
    input  logic signed [31:0] s_query_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_status,
    output logic [5:0]         m_bin_index,
    output logic [21:0]        m_bin_position
);

    ltb_pkg::cmd_t cmd;
    ltb_pkg::sts_t sts;

    ltb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ltb_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .s_op           (s_op),
        .s_entry_index  (s_entry_index),
        .s_entry_value  (s_entry_value),
        .s_level_count  (s_level_count),
        .s_range_min    (s_range_min),
        .s_range_max    (s_range_max),
        .s_query_value  (s_query_value),
        .m_status       (m_status),
        .m_bin_index    (m_bin_index),
        .m_bin_position (m_bin_position)
    );

endmodule

// ===== tb/level_threshold_binning_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// level_threshold_binning_tb
// Self-checking bench for the Q16.16 threshold quantizer. A short directed
// table hits reset contents, count limits and query extremes. A random mix
// of table writes, commits, fills and queries follows, with bursty input,
// patterned output stalls and one long output hold-off. Every result is
// checked against a fixed directed value or a local model of the level table.
// ----------------------------------------------------------------------------
module level_threshold_binning_tb;

    localparam int RANDOM_ITEMS = 530;
    localparam int STALL_LIMIT  = 5000;

    typedef struct {
        logic [1:0]         op;
        logic [4:0]         entry_index;
        logic signed [31:0] entry_value;
        logic [7:0]         level_count;
        logic signed [31:0] range_min;
        logic signed [31:0] range_max;
        logic signed [31:0] query_value;
    } bin_req_t;

    typedef struct {
        logic        status;
        logic [5:0]  bin_index;
        logic [21:0] bin_position;
    } bin_rsp_t;

    typedef struct {
        bin_req_t req;
        bit       typed;
        bin_rsp_t rsp;
    } dir_row_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_op;
    logic [4:0]         s_entry_index;
    logic signed [31:0] s_entry_value;
    logic [7:0]         s_level_count;
    logic signed [31:0] s_range_min;
    logic signed [31:0] s_range_max;
    logic signed [31:0] s_query_value;
    logic               m_valid;
    logic               m_ready;
    logic               m_status;
    logic [5:0]         m_bin_index;
    logic [21:0]        m_bin_position;

    // local copy of the table
    longint   levels [ltb_pkg::TABLE_DEPTH];
    int       n_active;
    bin_rsp_t pending_bins[$];
    dir_row_t dir_rows[$];
    int       errors;
    int       items_sent;
    bit       stim_done;

    level_threshold_binning uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_entry_index (s_entry_index),
        .s_entry_value (s_entry_value),
        .s_level_count (s_level_count),
        .s_range_min   (s_range_min),
        .s_range_max   (s_range_max),
        .s_query_value (s_query_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_bin_index   (m_bin_index),
        .m_bin_position(m_bin_position)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic void fill_levels(longint lo, longint hi, int n);
        longint step;
        n_active = n;
        if (n == 1) begin
            levels[0] = (lo + hi) / 2;
            return;
        end
        step = (hi - lo) / longint'(n - 1);
        for (int i = 0; i < n; i++) levels[i] = lo + step * i;
    endfunction

    function automatic void reset_levels();
        for (int i = 0; i < ltb_pkg::TABLE_DEPTH; i++) levels[i] = 0;
        fill_levels(0, 6553600, 8);
    endfunction

    // applies one item to the local table and returns its result
    function automatic bin_rsp_t bin_lookup(bin_req_t r);
        bin_rsp_t    o;
        longint      v;
        longint      num;
        longint      den;
        longint      pos;
        int          n;
        int          i;
        o = '{status: 1'b0, bin_index: '0, bin_position: '0};
        case (r.op)
            ltb_pkg::OP_WRITE: levels[r.entry_index] = longint'(r.entry_value);
            ltb_pkg::OP_COMMIT: begin
                if (r.level_count >= 1 && r.level_count <= ltb_pkg::TABLE_DEPTH)
                    n_active = r.level_count;
                else
                    o.status = 1'b1;
            end
            ltb_pkg::OP_FILL: begin
                if (r.level_count >= 1 && r.level_count <= ltb_pkg::TABLE_DEPTH)
                    fill_levels(longint'(r.range_min), longint'(r.range_max),
                                r.level_count);
                else
                    o.status = 1'b1;
            end
            default: begin
                v = longint'(r.query_value);
                n = n_active;
                o.bin_index = 6'(n);
                for (i = 0; i < n; i++) begin
                    if (v < levels[i]) begin
                        o.bin_index = 6'(i);
                        break;
                    end
                end
                if (v < levels[0]) begin
                    pos = 0;
                end else if (v > levels[n-1]) begin
                    pos = longint'(n) << 16;
                end else begin
                    for (i = 1; i < n; i++) if (v < levels[i]) break;
                    if (i == n) begin
                        pos = longint'(n - 1) << 16;
                    end else begin
                        num = v - levels[i-1];
                        den = levels[i] - levels[i-1];
                        pos = (longint'(i) << 16) + ((num << 16) / den);
                    end
                end
                o.bin_position = 22'(pos);
            end
        endcase
        return o;
    endfunction

    function automatic bin_req_t blank_req(logic [1:0] op);
        bin_req_t r;
        r.op          = op;
        r.entry_index = 5'($urandom);
        r.entry_value = $urandom;
        r.level_count = 8'($urandom);
        r.range_min   = $urandom;
        r.range_max   = $urandom;
        r.query_value = $urandom;
        return r;
    endfunction

    function automatic bin_req_t random_req();
        bin_req_t r;
        int       pick;
        int       k;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            r = blank_req(ltb_pkg::OP_QUERY);
            k = $urandom_range(0, n_active - 1);
            pick = $urandom_range(0, 9);
            if (pick < 6)
                r.query_value = 32'(levels[k] + $signed($urandom_range(0, 131072)) - 65536);
            else if (pick < 7)
                r.query_value = 32'(levels[k]);
        end else if (pick < 65) begin
            r = blank_req(ltb_pkg::OP_WRITE);
            k = r.entry_index;
            if ($urandom_range(0, 1) && k > 0)
                r.entry_value = 32'(levels[k-1] + $urandom_range(1, 200000));
        end else if (pick < 80) begin
            r = blank_req(ltb_pkg::OP_COMMIT);
            if ($urandom_range(0, 9) < 8)
                r.level_count = 8'($urandom_range(1, ltb_pkg::TABLE_DEPTH));
        end else begin
            r = blank_req(ltb_pkg::OP_FILL);
            if ($urandom_range(0, 9) < 8)
                r.level_count = 8'($urandom_range(1, ltb_pkg::TABLE_DEPTH));
            if ($urandom_range(0, 9) < 7) begin
                r.range_min = $signed($urandom_range(0, 2097152)) - 1048576;
                r.range_max = r.range_min + $signed($urandom_range(0, 4194304));
            end
        end
        return r;
    endfunction

    function automatic void add_row(bin_req_t r, bit typed, logic st, int bi, int bp);
        dir_row_t d;
        d.req   = r;
        d.typed = typed;
        d.rsp   = '{status: st, bin_index: 6'(bi), bin_position: 22'(bp)};
        dir_rows.push_back(d);
    endfunction

    task automatic send_item(bin_req_t r, bit typed, bin_rsp_t want);
        bin_rsp_t got;
        s_valid       <= 1'b1;
        s_op          <= r.op;
        s_entry_index <= r.entry_index;
        s_entry_value <= r.entry_value;
        s_level_count <= r.level_count;
        s_range_min   <= r.range_min;
        s_range_max   <= r.range_max;
        s_query_value <= r.query_value;
        do @(posedge aclk); while (!s_ready);
        got = bin_lookup(r);
        pending_bins.push_back(typed ? want : got);
        items_sent++;
        @(negedge aclk);
    endtask

    // sender
    initial begin
        bin_req_t r;
        int       burst;
        s_valid = 1'b0; s_op = ltb_pkg::OP_WRITE; s_entry_index = '0; s_entry_value = '0;
        s_level_count = '0; s_range_min = '0; s_range_max = '0; s_query_value = '0;
        aresetn = 1'b0;
        errors = 0; items_sent = 0; stim_done = 0;
        reset_levels();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        r = blank_req(ltb_pkg::OP_QUERY); r.query_value = 32'sh8000_0000;
        add_row(r, 1, 0, 0, 0);
        r.query_value = 32'sh7fff_ffff;                           add_row(r, 1, 0, 8, 8 << 16);
        r.query_value = 0;                                        add_row(r, 0, 0, 0, 0);
        r.query_value = 32'sd3000000;                             add_row(r, 0, 0, 0, 0);
        r.query_value = 32'sd6553599;                             add_row(r, 0, 0, 0, 0);
        r = blank_req(ltb_pkg::OP_COMMIT); r.level_count = 8'd0;  add_row(r, 1, 1, 0, 0);
        r.level_count = 8'(ltb_pkg::TABLE_DEPTH + 1);             add_row(r, 1, 1, 0, 0);
        r.level_count = 8'hff;                                    add_row(r, 1, 1, 0, 0);
        r = blank_req(ltb_pkg::OP_FILL); r.level_count = 8'd0;    add_row(r, 1, 1, 0, 0);
        r.level_count = 8'hff;                                    add_row(r, 1, 1, 0, 0);
        // single level lands on the midpoint
        r.level_count = 8'd1; r.range_min = 32'sh8000_0000; r.range_max = 32'sh7fff_ffff;
        add_row(r, 1, 0, 0, 0);
        r = blank_req(ltb_pkg::OP_QUERY); r.query_value = -1;     add_row(r, 0, 0, 0, 0);
        r.query_value = 0;                                        add_row(r, 0, 0, 0, 0);
        r = blank_req(ltb_pkg::OP_FILL); r.level_count = 8'(ltb_pkg::TABLE_DEPTH);
        r.range_min = 32'sh8000_0000; r.range_max = 32'sh7fff_ffff; add_row(r, 1, 0, 0, 0);
        r = blank_req(ltb_pkg::OP_QUERY); r.query_value = 32'sh7fff_fff0;
        add_row(r, 0, 0, 0, 0);
        r.query_value = 12345;                                    add_row(r, 0, 0, 0, 0);
        r = blank_req(ltb_pkg::OP_WRITE); r.entry_index = 5'd31;
        r.entry_value = 32'sh8000_0000;
        add_row(r, 1, 0, 0, 0);
        // unsorted table: last entry now lowest
        r = blank_req(ltb_pkg::OP_QUERY); r.query_value = 32'sh7fff_0000;
        add_row(r, 0, 0, 0, 0);
        r = blank_req(ltb_pkg::OP_COMMIT); r.level_count = 8'd1;  add_row(r, 1, 0, 0, 0);
        r = blank_req(ltb_pkg::OP_QUERY); r.query_value = 32'sh7fff_ffff;
        add_row(r, 0, 0, 0, 0);
        r.query_value = 32'sh8000_0000;                           add_row(r, 0, 0, 0, 0);
        r = blank_req(ltb_pkg::OP_COMMIT); r.level_count = 8'(ltb_pkg::TABLE_DEPTH);
        add_row(r, 1, 0, 0, 0);
        r = blank_req(ltb_pkg::OP_QUERY); r.query_value = 32'sh8000_0000;
        add_row(r, 0, 0, 0, 0);

        foreach (dir_rows[i]) send_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);

        while (items_sent < dir_rows.size() + RANDOM_ITEMS) begin
            burst = $urandom_range(1, 20);
            repeat (burst) send_item(random_req(), 0, '{1'b0, 6'd0, 22'd0});
            if ($urandom_range(0, 3) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge aclk);
            end
        end
        s_valid <= 1'b0;
        stim_done = 1;
    end

    // receiver: stall pattern is redrawn at random in repeated windows, one long hold-off
    initial begin
        int  mode;
        bit  held;
        m_ready = 1'b0;
        held = 0;
        @(posedge aresetn);
        forever begin
            mode = $urandom_range(0, 2);
            for (int c = 0; c < 64; c++) begin
                @(negedge aclk);
                if (!held && items_sent >= 150) begin
                    held = 1;
                    m_ready <= 1'b0;
                    repeat (400) @(negedge aclk);
                end
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    default: m_ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        bin_rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_bins.size() == 0) begin
                $error("unexpected result transfer");
                errors++;
            end else begin
                want = pending_bins.pop_front();
                if (m_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_status);
                    errors++;
                end
                if (m_bin_index !== want.bin_index) begin
                    $error("bin_index: expected %0d, got %0d", want.bin_index, m_bin_index);
                    errors++;
                end
                if (m_bin_position !== want.bin_position) begin
                    $error("bin_position: expected %0d, got %0d",
                           want.bin_position, m_bin_position);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer
    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle = 0;
            else idle++;
            if (idle >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        wait (stim_done);
        while (pending_bins.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
